FILE: rtl/core/tcs_pkg.sv
// Shared constants, status codes and index helpers for the circumsphere unit.
package tcs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int MUL_CHUNK = 16;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_DEGEN = 2'd1;
	localparam status_t STATUS_CLAMP = 2'd2;

	// 2x2 minor k uses the pair of rows/columns {lo_idx(k), hi_idx(k)}:
	// k = 0 -> {1,2}, k = 1 -> {0,2}, k = 2 -> {0,1}
	function automatic int lo_idx(input int k);
		return (k == 0) ? 1 : 0;
	endfunction

	function automatic int hi_idx(input int k);
		return (k == 2) ? 1 : 2;
	endfunction

endpackage

FILE: rtl/core/tcs_dly.sv
// Enable-gated delay line for payload that rides alongside the pipeline.
module tcs_dly
	import tcs_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sr_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sr_s[i] <= sr_s[i-1];
			end
		end
	end

	assign q = sr_s[DEPTH-1];

endmodule

FILE: rtl/core/tcs_mul.sv
// Pipelined signed multiplier, one MUL_CHUNK-bit slice of b per stage.
module tcs_mul
	import tcs_pkg::*;
#(
	parameter int AW = 16,
	parameter int BW = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BX  = NCH * MUL_CHUNK;
	localparam int AX  = AW + BX;

	logic signed [AW-1:0] a_s   [NCH];
	logic signed [BX-1:0] b_s   [NCH];
	logic signed [AX-1:0] acc_s [NCH];

	for (genvar k = 0; k < NCH; k++) begin : g_st
		logic signed [AW-1:0]          a_in;
		logic signed [BX-1:0]          b_in;
		logic signed [AX-1:0]          acc_in;
		logic [MUL_CHUNK-1:0]          dig;
		logic signed [MUL_CHUNK:0]     sdig;
		logic signed [AW+MUL_CHUNK:0]  prod;

		if (k == 0) begin : g_head
			assign a_in   = a;
			assign b_in   = BX'(b);
			assign acc_in = '0;
		end else begin : g_body
			assign a_in   = a_s[k-1];
			assign b_in   = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign dig  = b_in[k*MUL_CHUNK +: MUL_CHUNK];
		// top slice carries the sign of b
		assign sdig = (k == NCH - 1) ? {dig[MUL_CHUNK-1], dig} : {1'b0, dig};
		assign prod = a_in * sdig;

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]   <= a_in;
				b_s[k]   <= b_in;
				acc_s[k] <= acc_in + (AX'(prod) <<< (k * MUL_CHUNK));
			end
		end
	end

	assign p = acc_s[NCH-1][AW+BW-1:0];

endmodule

FILE: rtl/core/tcs_div.sv
// Pipelined restoring divider, truncating, saturating quotient magnitude.
module tcs_div
	import tcs_pkg::*;
#(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 4
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic [QW-1:0]        mag,
	output logic                 neg
);

	logic [NW-1:0] nmag;
	logic [DW-1:0] dmag;
	logic          ovf;

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] low_s [QW+1];
	logic          ng_s  [QW+1];
	logic          ov_s  [QW+1];

	assign nmag = $unsigned(num[NW-1] ? -num : num);
	assign dmag = $unsigned(den[DW-1] ? -den : den);
	assign ovf  = (nmag >> QW) >= NW'(dmag);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(nmag >> QW);
			low_s[0] <= nmag[QW-1:0];
			d_s[0]   <= dmag;
			ng_s[0]  <= num[NW-1] ^ den[DW-1];
			ov_s[0]  <= ovf;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [DW:0] t;
		logic        ge;

		assign t  = {rem_s[j-1], low_s[j-1][QW-1]};
		assign ge = t >= {1'b0, d_s[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				low_s[j] <= {low_s[j-1][QW-2:0], ge};
				ng_s[j]  <= ng_s[j-1];
				ov_s[j]  <= ov_s[j-1];
			end
		end

		if (j < QW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? DW'(t - {1'b0, d_s[j-1]}) : DW'(t);
					d_s[j]   <= d_s[j-1];
				end
			end
		end
	end

	assign mag = ov_s[QW] ? '1 : low_s[QW];
	assign neg = ng_s[QW];

endmodule

FILE: rtl/core/tcs_sqrt.sv
// Pipelined floored integer square root, one result bit per stage.
module tcs_sqrt
	import tcs_pkg::*;
#(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] s,
	output logic [W-1:0]   root
);

	logic [W+1:0]   rem_s  [W];
	logic [W-1:0]   root_s [W];
	logic [2*W-1:0] x_s    [W];

	for (genvar j = 0; j < W; j++) begin : g_step
		logic [W+1:0]   rem_p;
		logic [W-1:0]   root_p;
		logic [2*W-1:0] x_p;
		logic [W+3:0]   t;
		logic [W+3:0]   trial;
		logic           ge;

		if (j == 0) begin : g_head
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = s;
		end else begin : g_body
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign x_p    = x_s[j-1];
		end

		assign t     = {rem_p, x_p[2*W-1 -: 2]};
		assign trial = (W+4)'({root_p, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? (W+2)'(t - trial) : (W+2)'(t);
				root_s[j] <= {root_p[W-2:0], ge};
				x_s[j]    <= x_p << 2;
			end
		end
	end

	assign root = root_s[W-1];

endmodule

FILE: rtl/core/tetrahedron_circumsphere_unit.sv
// Circumsphere center and radius of a tetrahedron, fully pipelined.
//
// Input channel: in_valid / in_stall with the four points p0..p3 as
// signed fixed-point coordinates. A request is taken on a rising edge with
// in_valid high and in_stall low. Output channel: out_valid / out_stall with
// center_x/y/z, radius and status (ok, degenerate, clamped).
// One request is accepted every cycle while in_stall is low. The multipliers
// work in 16-bit slices; the quotient divider and the root unit (one bit per
// stage each) make up most of the pipeline depth.
// Reset clears all valid bits; data registers are not reset.
// When out_stall holds a result, the next finished result parks in a skid
// register; only then does in_stall rise and the whole pipeline freeze.
module tetrahedron_circumsphere_unit
	import tcs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p0_z,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] center_x,
	output logic signed [COORD_WIDTH-1:0] center_y,
	output logic signed [COORD_WIDTH-1:0] center_z,
	output logic [COORD_WIDTH-2:0]        radius,
	output status_t                       status
);

	localparam int W    = COORD_WIDTH;
	localparam int VW   = W + 1;
	localparam int XW   = 2 * VW + 2;
	localparam int PW   = 2 * XW;
	localparam int NW   = PW + 2;
	localparam int DW   = VW + XW + 3;
	localparam int QW   = W + 1;
	localparam int NCH1 = (VW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NCH2 = (XW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NCH3 = (W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int T1   = 1;
	localparam int T3   = T1 + NCH1 + 1;
	localparam int T5   = T3 + NCH2 + 1;
	localparam int T6   = T5 + 1 + QW;
	localparam int T7   = T6 + 1;
	localparam int T10  = T7 + NCH3 + 1 + W;

	logic en;
	logic skid_v_q;
	logic [T10-1:0] vld_q;
	logic res_v;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign res_v    = vld_q[T10-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T10-2:0], in_valid};
		end
	end

	// stage 1: offsets from point 0
	logic signed [W-1:0]  pt      [4][3];
	logic signed [VW-1:0] v_s1    [3][3];
	logic signed [W-1:0]  base_s1 [3];

	assign pt[0][0] = p0_x;
	assign pt[0][1] = p0_y;
	assign pt[0][2] = p0_z;
	assign pt[1][0] = p1_x;
	assign pt[1][1] = p1_y;
	assign pt[1][2] = p1_z;
	assign pt[2][0] = p2_x;
	assign pt[2][1] = p2_y;
	assign pt[2][2] = p2_z;
	assign pt[3][0] = p3_x;
	assign pt[3][1] = p3_y;
	assign pt[3][2] = p3_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					v_s1[i][k] <= VW'(pt[i+1][k]) - VW'(pt[0][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				base_s1[k] <= pt[0][k];
			end
		end
	end

	// squares and 2x2 minor products
	logic signed [2*VW-1:0] sq [3][3];
	logic signed [2*VW-1:0] pa [3][3];
	logic signed [2*VW-1:0] pb [3][3];

	for (genvar i = 0; i < 3; i++) begin : g_sq
		for (genvar k = 0; k < 3; k++) begin : g_c
			tcs_mul #(.AW(VW), .BW(VW)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (v_s1[i][k]),
				.b   (v_s1[i][k]),
				.p   (sq[i][k])
			);
		end
	end

	for (genvar p = 0; p < 3; p++) begin : g_mp
		for (genvar r = 0; r < 3; r++) begin : g_mr
			localparam int RI = lo_idx(r);
			localparam int RJ = hi_idx(r);
			localparam int CC = lo_idx(p);
			localparam int CD = hi_idx(p);

			tcs_mul #(.AW(VW), .BW(VW)) u_mula (
				.clk (clk),
				.en  (en),
				.a   (v_s1[RI][CC]),
				.b   (v_s1[RJ][CD]),
				.p   (pa[p][r])
			);
			tcs_mul #(.AW(VW), .BW(VW)) u_mulb (
				.clk (clk),
				.en  (en),
				.a   (v_s1[RI][CD]),
				.b   (v_s1[RJ][CC]),
				.p   (pb[p][r])
			);
		end
	end

	logic [3*VW-1:0]      vx_dly;
	logic signed [VW-1:0] vx_d [3];

	tcs_dly #(.WIDTH(3 * VW), .DEPTH(T3 - T1)) u_dly_vx (
		.clk (clk),
		.en  (en),
		.d   ({v_s1[0][0], v_s1[1][0], v_s1[2][0]}),
		.q   (vx_dly)
	);

	assign vx_d[0] = $signed(vx_dly[3*VW-1 -: VW]);
	assign vx_d[1] = $signed(vx_dly[2*VW-1 -: VW]);
	assign vx_d[2] = $signed(vx_dly[VW-1:0]);

	// stage 3: squared lengths and minors
	logic signed [XW-1:0] len_s3 [3];
	logic signed [XW-1:0] mnr_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				len_s3[i] <= XW'(sq[i][0]) + XW'(sq[i][1]) + XW'(sq[i][2]);
			end
			for (int p = 0; p < 3; p++) begin
				for (int r = 0; r < 3; r++) begin
					mnr_s3[p][r] <= XW'(pa[p][r]) - XW'(pb[p][r]);
				end
			end
		end
	end

	// cofactor products
	logic signed [PW-1:0] np [3][3];
	logic signed [PW-1:0] dp [3];

	for (genvar p = 0; p < 3; p++) begin : g_np
		for (genvar r = 0; r < 3; r++) begin : g_nr
			tcs_mul #(.AW(XW), .BW(XW)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (len_s3[r]),
				.b   (mnr_s3[p][r]),
				.p   (np[p][r])
			);
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_dp
		tcs_mul #(.AW(XW), .BW(XW)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (mnr_s3[0][r]),
			.b   (XW'(vx_d[r])),
			.p   (dp[r])
		);
	end

	// stage 5: numerators and twice the determinant
	logic signed [NW-1:0] nsum [3];
	logic signed [NW-1:0] dsum;
	logic signed [NW-1:0] num_s5 [3];
	logic signed [DW-1:0] aa_s5;
	logic                 deg_s5;

	always_comb begin
		for (int p = 0; p < 3; p++) begin
			nsum[p] = NW'(np[p][0]) - NW'(np[p][1]) + NW'(np[p][2]);
		end
		dsum = NW'(dp[0]) - NW'(dp[1]) + NW'(dp[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5[0] <= nsum[0];
			num_s5[1] <= -nsum[1];
			num_s5[2] <= nsum[2];
			aa_s5     <= DW'(dsum) <<< 1;
			deg_s5    <= (dsum == '0);
		end
	end

	logic [QW-1:0] qm [3];
	logic          qn [3];

	for (genvar k = 0; k < 3; k++) begin : g_div
		tcs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s5[k]),
			.den (aa_s5),
			.mag (qm[k]),
			.neg (qn[k])
		);
	end

	logic [3*W-1:0]      base_dly;
	logic signed [W-1:0] base_d [3];

	tcs_dly #(.WIDTH(3 * W), .DEPTH(T6 - T1)) u_dly_base (
		.clk (clk),
		.en  (en),
		.d   ({base_s1[0], base_s1[1], base_s1[2]}),
		.q   (base_dly)
	);

	assign base_d[0] = $signed(base_dly[3*W-1 -: W]);
	assign base_d[1] = $signed(base_dly[2*W-1 -: W]);
	assign base_d[2] = $signed(base_dly[W-1:0]);

	// stage 7: center, clamp, and root operands
	logic signed [W+1:0] qs   [3];
	logic signed [W+2:0] ctr  [3];
	logic signed [W-1:0] ctc  [3];
	logic                oor  [3];
	logic                big_c;

	always_comb begin
		big_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			qs[k]  = qn[k] ? -$signed((W+2)'(qm[k])) : $signed((W+2)'(qm[k]));
			ctr[k] = (W+3)'(qs[k]) + (W+3)'(base_d[k]);
			oor[k] = !((ctr[k][W+2:W-1] == '0) || (ctr[k][W+2:W-1] == '1));
			if (oor[k]) begin
				ctc[k] = ctr[k][W+2] ? $signed({1'b1, {(W-1){1'b0}}})
				                     : $signed({1'b0, {(W-1){1'b1}}});
			end else begin
				ctc[k] = ctr[k][W-1:0];
			end
			big_c = big_c | (qm[k][QW-1:W-1] != '0);
		end
	end

	logic signed [W-1:0] ctr_s7  [3];
	logic signed [W-1:0] sqin_s7 [3];
	logic                clp_s7;
	logic                big_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ctr_s7[k]  <= ctc[k];
				sqin_s7[k] <= big_c ? '0 : $signed({1'b0, qm[k][W-2:0]});
			end
			clp_s7 <= oor[0] | oor[1] | oor[2];
			big_s7 <= big_c;
		end
	end

	logic signed [2*W-1:0] sq3 [3];

	for (genvar k = 0; k < 3; k++) begin : g_sq3
		tcs_mul #(.AW(W), .BW(W)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (sqin_s7[k]),
			.b   (sqin_s7[k]),
			.p   (sq3[k])
		);
	end

	logic [2*W-1:0] s_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s9 <= $unsigned(sq3[0]) + $unsigned(sq3[1]) + $unsigned(sq3[2]);
		end
	end

	logic [W-1:0] root;

	tcs_sqrt #(.W(W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.s    (s_s9),
		.root (root)
	);

	logic [3*W+1:0] ctr_dly;
	logic           deg_d;

	tcs_dly #(.WIDTH(3 * W + 2), .DEPTH(T10 - T7)) u_dly_ctr (
		.clk (clk),
		.en  (en),
		.d   ({ctr_s7[0], ctr_s7[1], ctr_s7[2], clp_s7, big_s7}),
		.q   (ctr_dly)
	);

	tcs_dly #(.WIDTH(1), .DEPTH(T10 - T5)) u_dly_deg (
		.clk (clk),
		.en  (en),
		.d   (deg_s5),
		.q   (deg_d)
	);

	// result assembly
	logic signed [W-1:0] res_cx, res_cy, res_cz;
	logic [W-2:0]        res_rad;
	status_t             res_st;
	logic                rclp;

	always_comb begin
		rclp = ctr_dly[0] | root[W-1];
		if (deg_d) begin
			res_cx  = '0;
			res_cy  = '0;
			res_cz  = '0;
			res_rad = '0;
			res_st  = STATUS_DEGEN;
		end else begin
			res_cx  = $signed(ctr_dly[3*W+1 -: W]);
			res_cy  = $signed(ctr_dly[2*W+1 -: W]);
			res_cz  = $signed(ctr_dly[W+1 -: W]);
			res_rad = rclp ? '1 : root[W-2:0];
			res_st  = (rclp | ctr_dly[1]) ? STATUS_CLAMP : STATUS_OK;
		end
	end

	// output register with skid
	logic signed [W-1:0] sk_cx_q, sk_cy_q, sk_cz_q;
	logic [W-2:0]        sk_rad_q;
	status_t             sk_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_valid && out_stall) begin
			if (en && res_v) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_valid <= 1'b1;
			skid_v_q  <= 1'b0;
		end else begin
			out_valid <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && out_stall) begin
			if (en && res_v) begin
				sk_cx_q  <= res_cx;
				sk_cy_q  <= res_cy;
				sk_cz_q  <= res_cz;
				sk_rad_q <= res_rad;
				sk_st_q  <= res_st;
			end
		end else if (skid_v_q) begin
			center_x <= sk_cx_q;
			center_y <= sk_cy_q;
			center_z <= sk_cz_q;
			radius   <= sk_rad_q;
			status   <= sk_st_q;
		end else begin
			center_x <= res_cx;
			center_y <= res_cy;
			center_z <= res_cz;
			radius   <= res_rad;
			status   <= res_st;
		end
	end

`ifndef SYNTH
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_valid && out_stall))
		else $error("skid loaded while output was free");

	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid)
		else $error("skid holds a request with empty output");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_DEGEN) |->
		(center_x == '0 && center_y == '0 && center_z == '0 && radius == '0))
		else $error("degenerate request with nonzero fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(status == STATUS_OK || status == STATUS_DEGEN || status == STATUS_CLAMP))
		else $error("undefined status code");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the tetrahedron circumsphere unit.
`timescale 1ns / 1ps

module tb_top;
	import tcs_pkg::*;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [255:0] wide_t;

	typedef struct {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		logic [30:0] rad;
		status_t st;
	} sphere_t;

	class sphere_board;
		sphere_t pending_q[$];
		int errors;

		function void note(sphere_t s);
			pending_q.push_back(s);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check(sphere_t got);
			sphere_t want;
			if (pending_q.size() == 0) begin
				report("result with no request waiting");
				return;
			end
			want = pending_q.pop_front();
			if (got.cx !== want.cx) report($sformatf("center_x %h want %h", got.cx, want.cx));
			if (got.cy !== want.cy) report($sformatf("center_y %h want %h", got.cy, want.cy));
			if (got.cz !== want.cz) report($sformatf("center_z %h want %h", got.cz, want.cz));
			if (got.rad !== want.rad) report($sformatf("radius %h want %h", got.rad, want.rad));
			if (got.st !== want.st) report($sformatf("status %0d want %0d", got.st, want.st));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t pt [12];
	logic out_valid;
	logic out_stall;
	coord_t center_x, center_y, center_z;
	logic [30:0] radius;
	status_t status;

	sphere_board sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	tetrahedron_circumsphere_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.p0_x(pt[0]), .p0_y(pt[1]), .p0_z(pt[2]),
		.p1_x(pt[3]), .p1_y(pt[4]), .p1_z(pt[5]),
		.p2_x(pt[6]), .p2_y(pt[7]), .p2_z(pt[8]),
		.p3_x(pt[9]), .p3_y(pt[10]), .p3_z(pt[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.radius(radius), .status(status)
	);

	function automatic sphere_t circumsphere(coord_t c [12]);
		wide_t v [3][3];
		wide_t len [3];
		wide_t yz [3], xz [3], xy [3];
		wide_t num [3];
		wide_t det, den, q, ctr, sq;
		wide_t hi, lo, cand;
		logic big;
		sphere_t r;
		coord_t cc [3];
		logic [31:0] rt;
		hi = 256'sd2147483647;
		lo = -256'sd2147483648;
		big = 1'b0;
		r.st = STATUS_OK;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				v[i][k] = wide_t'(c[3*(i+1)+k]) - wide_t'(c[k]);
			len[i] = v[i][0]*v[i][0] + v[i][1]*v[i][1] + v[i][2]*v[i][2];
		end
		// rows {1,2}, {0,2}, {0,1}
		for (int m = 0; m < 3; m++) begin
			int a, b;
			a = (m == 0) ? 1 : 0;
			b = (m == 2) ? 1 : 2;
			yz[m] = v[a][1]*v[b][2] - v[a][2]*v[b][1];
			xz[m] = v[a][0]*v[b][2] - v[a][2]*v[b][0];
			xy[m] = v[a][0]*v[b][1] - v[a][1]*v[b][0];
		end
		num[0] = len[0]*yz[0] - len[1]*yz[1] + len[2]*yz[2];
		num[1] = -(len[0]*xz[0] - len[1]*xz[1] + len[2]*xz[2]);
		num[2] = len[0]*xy[0] - len[1]*xy[1] + len[2]*xy[2];
		det = v[0][0]*yz[0] - v[1][0]*yz[1] + v[2][0]*yz[2];
		den = det + det;
		if (den == 0) begin
			r.cx = '0; r.cy = '0; r.cz = '0; r.rad = '0;
			r.st = STATUS_DEGEN;
			return r;
		end
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			q = num[k] / den;
			// offset magnitude of 2^31 or more saturates the radius
			if (q > hi || q <= lo) big = 1'b1;
			else sq = sq + q*q;
			ctr = q + wide_t'(c[k]);
			if (ctr > hi) begin ctr = hi; r.st = STATUS_CLAMP; end
			if (ctr < lo) begin ctr = lo; r.st = STATUS_CLAMP; end
			cc[k] = ctr[31:0];
		end
		r.cx = cc[0]; r.cy = cc[1]; r.cz = cc[2];
		if (big) begin
			r.rad = 31'h7fffffff;
			r.st = STATUS_CLAMP;
		end else begin
			rt = 0;
			for (int b = 31; b >= 0; b--) begin
				cand = {224'd0, rt | (32'd1 << b)};
				if (cand*cand <= sq) rt = cand[31:0];
			end
			if (rt > 32'h7fffffff) begin
				rt = 32'h7fffffff;
				r.st = STATUS_CLAMP;
			end
			r.rad = rt[30:0];
		end
		return r;
	endfunction

	task automatic send_request(coord_t c [12]);
		in_valid <= 1'b1;
		for (int i = 0; i < 12; i++) pt[i] <= c[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note(circumsphere(c));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// random tetrahedron: kinds 0-5 small offsets, 6-7 full range, 8-9 wide offsets; kind 9 and 1 in 16 of all coplanar
	function automatic void rand_tetra(output coord_t c [12]);
		int kind, sh;
		kind = $urandom_range(9);
		sh = $urandom_range(4, 24);
		for (int k = 0; k < 3; k++) c[k] = $urandom;
		for (int i = 3; i < 12; i++) begin
			if (kind <= 5)
				c[i] = c[i%3] + (coord_t'($signed($urandom)) >>> sh);
			else if (kind <= 7)
				c[i] = $urandom;
			else
				c[i] = c[i%3] + (coord_t'($signed($urandom)) >>> 2);
		end
		if (kind == 9 || $urandom_range(15) == 0)
			for (int k = 0; k < 3; k++) c[9+k] = c[3+k] + c[6+k] - c[k];
	endfunction

	task automatic directed_set();
		coord_t c [12];
		int unit [12] = '{0,0,0, 1,0,0, 0,1,0, 0,0,1};
		for (int i = 0; i < 12; i++) c[i] = 0;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] <<< 16;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] ? 32'sh7fffffff : 32'sh80000000;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] ? 32'sh80000000 : 32'sh7fffffff;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] ? 32'sh7fffffff : 32'sh0;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] ? 32'sh1 : 32'sh0;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = unit[i] ? -32'sh10000 : 32'sh7fff0000;
		send_request(c);
		// nearly flat: centre far away
		for (int i = 0; i < 12; i++) c[i] = unit[i] <<< 24;
		c[11] = 1;
		send_request(c);
		c[11] = 0;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = 32'sh12345678;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
		send_request(c);
		for (int i = 0; i < 12; i++) c[i] = (unit[i] <<< 30) - 32'sh40000000;
		send_request(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check('{center_x, center_y, center_z, radius, status});
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		coord_t c [12];
		int idle_pct [4] = '{0, 61, 0, 28};
		int stall_pct [4] = '{0, 0, 61, 28};
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		for (int i = 0; i < 12; i++) pt[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = idle_pct[ph%4];
			recv_stall_pct = stall_pct[ph%4];
			if (ph == 1) hold_cycles = 400;
			for (int n = 0; n < 230; n++) begin
				rand_tetra(c);
				send_request(c);
			end
			if (ph == 4) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending_q.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
